[rtl/lirs_pkg.sv]
// shared constants and controller/datapath interface types for the linear interpolation resampler
package lirs_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int RATE_W      = 18;
  localparam int SUM_W       = 20;
  localparam int CNT_W       = 4;
  localparam int MAX_RESULTS = 12;

  // output rate and allowed source rate window
  localparam logic [RATE_W-1:0] OUT_RATE   = 18'd44100;
  localparam logic [RATE_W-1:0] RATE_MIN   = 18'd8000;
  localparam logic [RATE_W-1:0] RATE_MAX   = 18'd192000;
  localparam logic [RATE_W-1:0] RATE_RESET = 18'd22050;

  // phase marker that means the clip length stopped the outputs
  localparam logic [RATE_W-1:0] R_STOP = 18'd88200;

  localparam logic [SUM_W-1:0] OUT_RATE_S     = 20'd44100;
  localparam logic [SUM_W-1:0] TWO_OUT_RATE_S = 20'd88200;

  // exact reciprocal of 44100 for 31-bit dividends: ceil(2^47 / 44100)
  localparam logic [31:0] RECIP       = 32'd3191326267;
  localparam int          RECIP_SHIFT = 47;

  // commands from the controller to the datapath
  typedef struct packed {
    logic                load_x;
    logic                prior_load;
    logic                issue;
    logic                a_sel_x;
    logic [SAMPLE_W-1:0] frac;
    logic                last;
    logic                done;
  } lirs_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic advance;
  } lirs_stat_t;

endpackage

[rtl/lirs_ctrl.sv]
// controller: phase tracking, output sequencing and the rate register
module lirs_ctrl import lirs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              s_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [RATE_W-1:0] cfg_data,
  input  lirs_stat_t        stat,
  output lirs_cmd_t         cmd
);

  typedef enum logic [2:0] {
    IDLE   = 3'b001,
    INTERP = 3'b010,
    HOLD   = 3'b100
  } state_t;

  state_t            state;
  logic [RATE_W-1:0] rate_reg;
  logic [RATE_W-1:0] rate;
  logic [RATE_W:0]   rate2;
  logic [RATE_W-1:0] r;
  logic [CNT_W-1:0]  n;
  logic              clip_end;
  logic              have_prior;
  logic [RATE_W-1:0] phase;

  logic [RATE_W-1:0] rate_eff;
  logic [SUM_W-1:0]  s1;
  logic [SUM_W-1:0]  s2;
  logic [CNT_W-1:0]  n_inc;
  logic              r_lt;
  logic              n_ok;
  logic              n_inc_ok;
  logic              interp_go;
  logic              hold_go;
  logic              interp_more;
  logic              hold_after;
  logic              hold_more;
  logic [RATE_W-1:0] r_post;
  logic              accept;

  assign s_tready  = (state == IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && (state == IDLE);

  // clamp the written rate to the supported window
  always_comb begin
    priority if (rate_reg < RATE_MIN) begin
      rate_eff = RATE_MIN;
    end else if (rate_reg > RATE_MAX) begin
      rate_eff = RATE_MAX;
    end else begin
      rate_eff = rate_reg;
    end
  end

  // phase sums and loop conditions, current and one output ahead
  always_comb begin
    s1          = {2'b00, r} + {2'b00, rate};
    s2          = {2'b00, r} + {1'b0, rate2};
    n_inc       = n + CNT_W'(1);
    r_lt        = (r < OUT_RATE);
    n_ok        = (n < CNT_W'(MAX_RESULTS));
    n_inc_ok    = (n_inc < CNT_W'(MAX_RESULTS));
    interp_go   = have_prior && r_lt && n_ok && (!clip_end || s1 <= TWO_OUT_RATE_S);
    hold_go     = (s1 <= OUT_RATE_S) && n_ok;
    interp_more = (s1 < OUT_RATE_S) && n_inc_ok && (!clip_end || s2 <= TWO_OUT_RATE_S);
    hold_after  = clip_end && (s1 >= OUT_RATE_S) && (s2 <= TWO_OUT_RATE_S) && n_inc_ok;
    hold_more   = (s2 <= OUT_RATE_S) && n_inc_ok;
  end

  // phase left after the interpolation run
  always_comb begin
    priority if (!have_prior) begin
      r_post = '0;
    end else if (!r_lt) begin
      r_post = r - OUT_RATE;
    end else begin
      r_post = R_STOP;
    end
  end

  // datapath commands
  always_comb begin
    cmd        = '0;
    cmd.load_x = accept;
    unique case (state)
      IDLE: begin
      end
      INTERP: begin
        if (interp_go) begin
          cmd.issue = stat.advance;
          cmd.frac  = r[SAMPLE_W-1:0];
          cmd.last  = !(interp_more || hold_after);
          cmd.done  = !(interp_more || hold_after) && clip_end;
        end else begin
          cmd.prior_load = 1'b1;
        end
      end
      HOLD: begin
        if (hold_go) begin
          cmd.issue   = stat.advance;
          cmd.a_sel_x = 1'b1;
          cmd.last    = !hold_more;
          cmd.done    = !hold_more;
        end
      end
      default: begin
      end
    endcase
  end

  // rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_reg <= RATE_RESET;
    end else if (cfg_valid) begin
      rate_reg <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      have_prior <= 1'b0;
      phase      <= '0;
      r          <= '0;
      n          <= '0;
      clip_end   <= 1'b0;
      rate       <= RATE_RESET;
      rate2      <= {RATE_RESET, 1'b0};
    end else begin
      unique case (state)
        IDLE: begin
          if (accept) begin
            rate     <= rate_eff;
            rate2    <= {rate_eff, 1'b0};
            r        <= phase;
            n        <= '0;
            clip_end <= s_tlast;
            state    <= INTERP;
          end
        end
        INTERP: begin
          if (interp_go) begin
            if (stat.advance) begin
              r <= s1[RATE_W-1:0];
              n <= n_inc;
            end
          end else begin
            have_prior <= 1'b1;
            if (clip_end) begin
              r     <= r_post;
              state <= HOLD;
            end else begin
              phase <= r_post;
              state <= IDLE;
            end
          end
        end
        HOLD: begin
          if (hold_go) begin
            if (stat.advance) begin
              r <= s1[RATE_W-1:0];
              n <= n_inc;
            end
          end else begin
            have_prior <= 1'b0;
            phase      <= '0;
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/lirs_datapath.sv]
// datapath: sample registers, weighted sum, divide by 44100 and output register
module lirs_datapath import lirs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [SAMPLE_W-1:0] s_tdata,
  input  lirs_cmd_t           cmd,
  output lirs_stat_t          stat,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata,
  output logic                m_tlast,
  output logic                m_tuser
);

  logic                advance;
  logic [SAMPLE_W-1:0] x;
  logic [SAMPLE_W-1:0] prior;
  logic [SAMPLE_W-1:0] a;
  logic [SAMPLE_W-1:0] wa;

  logic                v1, v2, v3;
  logic                last1, last2, last3;
  logic                done1, done2, done3;
  logic signed [32:0]  p1;
  logic signed [32:0]  p2;
  logic signed [33:0]  num;
  logic signed [33:0]  num_abs;
  logic                neg2, neg3;
  logic [30:0]         mag2;
  logic [62:0]         prod3;
  logic [SAMPLE_W-1:0] q;
  logic [SAMPLE_W:0]   qs;
  logic [SAMPLE_W-1:0] sat;

  assign advance      = !m_tvalid || m_tready;
  assign stat.advance = advance;

  // current and previous source samples
  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x <= s_tdata;
    end
    if (cmd.prior_load) begin
      prior <= x;
    end
  end

  // operand select: holds use the current sample with zero fraction
  always_comb begin
    a  = cmd.a_sel_x ? x : prior;
    wa = OUT_RATE[SAMPLE_W-1:0] - cmd.frac;
  end

  // stage 1: the two weighted products
  always_ff @(posedge clk) begin
    if (advance) begin
      p1    <= $signed(a) * $signed({1'b0, wa});
      p2    <= $signed(x) * $signed({1'b0, cmd.frac});
      last1 <= cmd.last;
      done1 <= cmd.done;
    end
  end

  // stage 2: sum and magnitude
  always_comb begin
    num     = 34'(p1) + 34'(p2);
    num_abs = num[33] ? -num : num;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      neg2  <= num[33];
      mag2  <= num_abs[30:0];
      last2 <= last1;
      done2 <= done1;
    end
  end

  // stage 3: reciprocal multiply
  always_ff @(posedge clk) begin
    if (advance) begin
      prod3 <= 63'(mag2) * 63'(RECIP);
      neg3  <= neg2;
      last3 <= last2;
      done3 <= done2;
    end
  end

  // stage 4: quotient, sign and saturation
  always_comb begin
    q  = prod3[RECIP_SHIFT+SAMPLE_W-1:RECIP_SHIFT];
    qs = neg3 ? -{1'b0, q} : {1'b0, q};
    priority if (!qs[SAMPLE_W] && qs[SAMPLE_W-1]) begin
      sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (qs[SAMPLE_W] && !qs[SAMPLE_W-1]) begin
      sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat = qs[SAMPLE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= sat;
      m_tlast <= last3;
      m_tuser <= done3;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      v1       <= cmd.issue;
      v2       <= v1;
      v3       <= v2;
      m_tvalid <= v3;
    end
  end

endmodule

[rtl/linear_interp_resampler_core.sv]
// top level of the linear interpolation resampler to 44100 Hz
//
//   channel  direction  handshake           payload
//   s_*      in         s_tvalid/s_tready   s_tdata = sample, s_tlast = clip_end
//   m_*      out        m_tvalid/m_tready   m_tdata = out_sample, m_tlast = run_last,
//                                           m_tuser = clip_done
//   cfg_*    in         cfg_valid/cfg_ready cfg_data = source_rate
//
// a sample is accepted in IDLE; the sequencer then issues its interpolated outputs in INTERP and,
// at the end of a clip, its held outputs in HOLD, one output per cycle while the output is not stalled.
// results pass from issue through a 4-deep multiply/divide pipeline that ends in the output register.
// reset is synchronous; it clears the clip state and loads the rate with 22050.
// a stalled output register freezes the whole pipeline and stops the sequencer issuing outputs.
module linear_interp_resampler_core import lirs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata,   // [15:0] out_sample
  output logic                m_tlast,
  output logic                m_tuser,   // [0] clip_done
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [RATE_W-1:0]   cfg_data
);

  lirs_cmd_t  cmd;
  lirs_stat_t stat;

  lirs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .cmd       (cmd)
  );

  lirs_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

[tb/linear_interp_resampler_core_test.sv]
// self-checking testbench for the linear interpolation resampler core
module linear_interp_resampler_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lirs_pkg::*;

  localparam int SETTLE    = 32;
  localparam int PLAN_LEN  = 25;
  localparam int RAND_GOAL = 85;
  localparam int HOLD_OFF  = 300;

  // one expected output transfer
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       run_last;
    logic                       clip_done;
  } resamp_t;

  // one row of the directed stimulus
  typedef struct packed {
    logic                       do_cfg;
    logic [RATE_W-1:0]          cfg_val;
    logic signed [SAMPLE_W-1:0] smp;
    logic                       last;
    logic                       typed;
    logic [3:0]                 typed_n;
    logic signed [SAMPLE_W-1:0] typed_val;
  } plan_row_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata   = '0;
  logic                s_tlast   = 1'b0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [SAMPLE_W-1:0] m_tdata;
  logic                m_tlast;
  logic                m_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [RATE_W-1:0]   cfg_data  = '0;

  // predictor state, mirrors the block after reset
  logic [RATE_W-1:0]          rate_reg = RATE_RESET;
  logic signed [SAMPLE_W-1:0] held_smp = '0;
  logic [RATE_W-1:0]          phase    = '0;
  logic                       primed   = 1'b0;

  logic signed [SAMPLE_W-1:0] step_smp [$];
  resamp_t                    resampled_q [$];
  int                         mismatch_cnt = 0;
  bit                         stall_req    = 1'b0;

  // directed rows: extremes, first sample, rate clamping, mid-clip rate change,
  // clips that end with no outputs left
  plan_row_t plan [PLAN_LEN] = '{
    '{1'b0, 18'd0,      32767,  1'b1, 1'b1, 4'd2, 32767},
    '{1'b0, 18'd0,      -32768, 1'b1, 1'b1, 4'd2, -32768},
    '{1'b0, 18'd0,      4660,   1'b0, 1'b1, 4'd0, 0},
    '{1'b0, 18'd0,      -1000,  1'b0, 1'b0, 4'd0, 0},
    '{1'b0, 18'd0,      100,    1'b1, 1'b0, 4'd0, 0},
    '{1'b1, 18'd8000,   32767,  1'b0, 1'b1, 4'd0, 0},
    '{1'b0, 18'd0,      -32768, 1'b0, 1'b0, 4'd0, 0},
    '{1'b0, 18'd0,      32767,  1'b0, 1'b0, 4'd0, 0},
    '{1'b1, 18'd192000, 0,      1'b0, 1'b0, 4'd0, 0},
    '{1'b0, 18'd0,      1,      1'b1, 1'b0, 4'd0, 0},
    '{1'b0, 18'd0,      500,    1'b1, 1'b1, 4'd0, 0},
    '{1'b1, 18'd0,      -5,     1'b1, 1'b1, 4'd5, -5},
    '{1'b1, 18'd262143, 7,      1'b1, 1'b1, 4'd0, 0},
    '{1'b0, 18'd0,      -32768, 1'b0, 1'b1, 4'd0, 0},
    '{1'b0, 18'd0,      32767,  1'b0, 1'b0, 4'd0, 0},
    '{1'b0, 18'd0,      32767,  1'b1, 1'b0, 4'd0, 0},
    '{1'b1, 18'd44100,  1000,   1'b0, 1'b1, 4'd0, 0},
    '{1'b0, 18'd0,      -1000,  1'b0, 1'b0, 4'd0, 0},
    '{1'b0, 18'd0,      21845,  1'b1, 1'b0, 4'd0, 0},
    '{1'b1, 18'd48000,  32767,  1'b0, 1'b1, 4'd0, 0},
    '{1'b0, 18'd0,      -32768, 1'b0, 1'b0, 4'd0, 0},
    '{1'b0, 18'd0,      10922,  1'b1, 1'b0, 4'd0, 0},
    '{1'b1, 18'd7999,   300,    1'b1, 1'b1, 4'd5, 300},
    '{1'b1, 18'd192001, -2,     1'b0, 1'b1, 4'd0, 0},
    '{1'b0, 18'd0,      3,      1'b1, 1'b0, 4'd0, 0}
  };

  linear_interp_resampler_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // effective source rate after clamping
  function automatic int unsigned clamp_rate(input logic [RATE_W-1:0] v);
    if (v < RATE_MIN) return RATE_MIN;
    if (v > RATE_MAX) return RATE_MAX;
    return v;
  endfunction

  // weighted mix of two neighbors, truncated toward zero and saturated
  function automatic logic signed [SAMPLE_W-1:0] blend(input logic signed [SAMPLE_W-1:0] a,
                                                       input logic signed [SAMPLE_W-1:0] b,
                                                       input int unsigned r);
    longint wa;
    longint wb;
    longint num;
    longint q;
    wb  = r;
    wa  = 44100 - wb;
    num = longint'(a) * wa + longint'(b) * wb;
    q   = num / 44100;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[SAMPLE_W-1:0];
  endfunction

  // outputs caused by one source sample; fills step_smp and advances the phase
  function automatic void resample_step(input logic signed [SAMPLE_W-1:0] x, input logic last);
    int unsigned rate;
    int unsigned r;
    step_smp.delete();
    rate = clamp_rate(rate_reg);
    r    = phase;
    if (primed) begin
      while (r < OUT_RATE && step_smp.size() < MAX_RESULTS &&
             (!last || r + rate <= 2 * 44100)) begin
        step_smp.insert(step_smp.size(), blend(held_smp, x, r));
        r += rate;
      end
      // a clip that stopped on its length gets no held outputs
      if (r >= OUT_RATE) r -= OUT_RATE;
      else r = R_STOP;
    end else begin
      r = 0;
    end
    held_smp = x;
    primed   = 1'b1;
    if (last) begin
      // hold the final sample up to the clip length
      while (r + rate <= OUT_RATE && step_smp.size() < MAX_RESULTS) begin
        step_smp.insert(step_smp.size(), x);
        r += rate;
      end
      held_smp = '0;
      phase    = '0;
      primed   = 1'b0;
    end else begin
      phase = r[RATE_W-1:0];
    end
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return SAMPLE_W'(int'($urandom_range(0, 15)) - 8);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0: return RATE_MIN;
      1: return RATE_MAX;
      2: return OUT_RATE;
      3: return RATE_W'($urandom_range(0, 262143));
      4, 5: return RATE_W'($urandom_range(8000, 48000));
      default: return RATE_W'($urandom_range(8000, 192000));
    endcase
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // stop offering and wait until every expected output has come out
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (resampled_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // source_rate write, only with the block idle
  task automatic set_rate(input logic [RATE_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    rate_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one input transfer; queues the typed or the predicted outputs
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] x, input logic last,
                             input logic typed, input int typed_n,
                             input logic signed [SAMPLE_W-1:0] typed_val, input bit eager);
    int gap;
    int n;
    gap = eager ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    resample_step(x, last);
    if (typed) begin
      step_smp.delete();
      repeat (typed_n) step_smp.insert(step_smp.size(), typed_val);
    end
    n = step_smp.size();
    for (int i = 0; i < n; i++) begin
      resampled_q.insert(resampled_q.size(),
                         resamp_t'{step_smp[i], i == n - 1, (i == n - 1) && last});
    end
  endtask

  // sender: directed rows, then random clips
  initial begin
    int rand_items;
    int len;
    int wait_cnt;
    bit burst;
    bit burst_done;
    rand_items = 0;
    burst_done = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int k = 0; k < PLAN_LEN; k++) begin
      if (plan[k].do_cfg) set_rate(plan[k].cfg_val);
      push_sample(plan[k].smp, plan[k].last, plan[k].typed, plan[k].typed_n,
                  plan[k].typed_val, 1'b0);
    end

    while (rand_items < RAND_GOAL) begin
      burst = 1'b0;
      if ($urandom_range(0, 1) == 1) set_rate(pick_rate());
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 20);
      // long receiver hold-off while samples keep coming back to back
      if (!burst_done && rand_items >= 30) begin
        burst      = 1'b1;
        burst_done = 1'b1;
        stall_req  = 1'b1;
        len        = 24;
      end
      for (int i = 0; i < len; i++) begin
        if (!burst && i > 0 && $urandom_range(0, 11) == 0) set_rate(pick_rate());
        push_sample(pick_sample(), i == len - 1, 1'b0, 0, '0, burst);
        rand_items++;
      end
      if (burst || $urandom_range(0, 7) == 0) drain();
    end

    // wait out the tail
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_cnt = 0;
    while (resampled_q.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (SETTLE) @(posedge clk);
    if (resampled_q.size() != 0) begin
      flag_mismatch($sformatf("%0d expected outputs never arrived", resampled_q.size()));
      mismatch_cnt += resampled_q.size() - 1;
    end
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin
    int hold;
    hold = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        hold      = HOLD_OFF;
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  // check each output transfer against the oldest expectation
  always @(posedge clk) begin
    resamp_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (resampled_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected output: sample %0d last %0b done %0b",
                                $signed(m_tdata), m_tlast, m_tuser));
      end else begin
        want = resampled_q.pop_front();
        if (want.smp !== m_tdata || want.run_last !== m_tlast ||
            want.clip_done !== m_tuser) begin
          flag_mismatch($sformatf(
            "bad output: exp sample %0d last %0b done %0b, got sample %0d last %0b done %0b",
            want.smp, want.run_last, want.clip_done, $signed(m_tdata), m_tlast, m_tuser));
        end
      end
    end
  end

  // watchdog
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
